FILE: sv/itel_pkg.sv
// ----------------------------------------------------------------------------
// Idle timeout expiry list package
// Shared widths, operation codes and parameter defaults for the expiry list.
// ----------------------------------------------------------------------------
package itel_pkg;

  // Field widths of the command, result and timeout words.
  localparam int OP_W         = 2;
  localparam int SLOT_FIELD_W = 5;
  localparam int TIMEOUT_W    = 20;

  // Default sizes handed to the top level.
  localparam int SLOTS_DEFAULT     = 32;
  localparam int TIME_BITS_DEFAULT = 32;

  // Reset value of the idle timeout register.
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd1000;

  // Operation codes; the fourth code is unused and is accepted as a no-op.
  localparam logic [OP_W-1:0] OP_TOUCH  = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

endpackage

FILE: sv/idle_timeout_expiry_list_core.sv
// ----------------------------------------------------------------------------
// Idle timeout expiry list
// Keeps connection slots in a doubly linked list ordered by last touch and
// reports slots that were removed or whose idle deadline has passed.
// ----------------------------------------------------------------------------
//
//   channel   | direction | handshake                     | word
//   ----------+-----------+-------------------------------+-------------------------
//   command   | in        | start high while busy low     | operation, slot_index
//   result    | out       | result_valid, one cycle each  | closed_slot, last_of_run
//   timeout   | in        | timeout_valid && timeout_ready| timeout_ticks
//
// A command word is taken while busy is low and then keeps the block busy while a
// small sequencer walks the list through one shared read port per memory. Touch
// passes the unlink state (when the slot must first be unlinked) and the append
// state, remove of a present slot the unlink state, and a tick the head and check
// states for each expired slot, then head and, unless the list is empty, check to
// find the end of the run. The unused code and commands on absent or out-of-range
// slots return to idle at once. Reset is synchronous and active high; no memory is
// cleared, because link and deadline entries are read only for slots whose member
// flag is set. Results cannot be stalled: each word is shown for exactly one cycle.
//
module idle_timeout_expiry_list_core #(
  parameter int SLOTS     = itel_pkg::SLOTS_DEFAULT,
  parameter int TIME_BITS = itel_pkg::TIME_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  // Command channel.
  input  logic                              start,
  output logic                              busy,
  input  logic [itel_pkg::OP_W-1:0]         operation,
  input  logic [itel_pkg::SLOT_FIELD_W-1:0] slot_index,
  // Result channel.
  output logic                              result_valid,
  output logic [itel_pkg::SLOT_FIELD_W-1:0] closed_slot,
  output logic                              last_of_run,
  // Timeout register write channel.
  input  logic                              timeout_valid,
  output logic                              timeout_ready,
  input  logic [itel_pkg::TIMEOUT_W-1:0]    timeout_ticks
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int SF_W   = itel_pkg::SLOT_FIELD_W;
  // The deadline sum is formed wide enough for both operands, then wrapped.
  localparam int SUM_W  = (TIME_BITS > itel_pkg::TIMEOUT_W) ? TIME_BITS
                                                            : itel_pkg::TIMEOUT_W;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_UNLINK = 3'd1;
  localparam logic [2:0] ST_APPEND = 3'd2;
  localparam logic [2:0] ST_HEAD   = 3'd3;
  localparam logic [2:0] ST_CHECK  = 3'd4;

  // Control and list state.
  logic [2:0]                     state, state_next;
  logic [itel_pkg::OP_W-1:0]      op_reg, op_reg_next;
  logic [SLOT_W-1:0]              slot_reg, slot_reg_next;
  logic [TIME_BITS-1:0]           now_count, now_count_next;
  logic [SLOT_W-1:0]              head_slot, head_slot_next;
  logic [SLOT_W-1:0]              tail_slot, tail_slot_next;
  logic                           list_empty, list_empty_next;
  logic [SLOTS-1:0]               member_flag, member_flag_next;
  logic [itel_pkg::TIMEOUT_W-1:0] timeout_reg;

  // A popped slot waits here until the next head check tells whether it
  // ends the run.
  logic                           pend_valid, pend_valid_next;
  logic [SLOT_W-1:0]              pend_slot, pend_slot_next;

  logic                           result_valid_next;
  logic [SF_W-1:0]                closed_slot_next;
  logic                           last_of_run_next;

  // Link and deadline memories, one write and one read port each.
  logic [SLOT_W-1:0]              prev_mem [SLOTS];
  logic [SLOT_W-1:0]              next_mem [SLOTS];
  logic [TIME_BITS-1:0]           deadline_mem [SLOTS];

  logic [SLOT_W-1:0]              rd_addr;
  logic [SLOT_W-1:0]              rd_prev;
  logic [SLOT_W-1:0]              rd_next;
  logic [TIME_BITS-1:0]           rd_deadline;

  logic                           prev_we, next_we, deadline_we;
  logic [SLOT_W-1:0]              prev_wa, next_wa;
  logic [SLOT_W-1:0]              prev_wd, next_wd;
  logic [TIME_BITS-1:0]           deadline_wd;

  logic [SLOT_W-1:0]              slot_ext;
  logic                           slot_ok;
  logic                           member_hit;
  logic [SUM_W-1:0]               deadline_sum;
  logic [TIME_BITS-1:0]           age;
  logic                           expired;

  assign busy          = (state != ST_IDLE);
  assign timeout_ready = 1'b1;

  // Slot numbers at or above SLOTS are treated as absent.
  assign slot_ext   = SLOT_W'(slot_index);
  assign slot_ok    = (32'(slot_index) < SLOTS);
  assign member_hit = slot_ok && member_flag[slot_ext];

  // New deadline for a touch; wraps modulo the time counter width.
  assign deadline_sum = SUM_W'(now_count) + SUM_W'(timeout_reg);
  assign deadline_wd  = deadline_sum[TIME_BITS-1:0];

  // A deadline has passed when the wrapped age is nonzero and in the lower
  // half of the time range.
  assign age     = now_count - rd_deadline;
  assign expired = (age != '0) && !age[TIME_BITS-1];

  // While idle the memories look up the incoming slot; during a tick they
  // look up the current head.
  assign rd_addr = (state == ST_IDLE) ? slot_ext : head_slot;

  always_comb begin
    state_next        = state;
    op_reg_next       = op_reg;
    slot_reg_next     = slot_reg;
    now_count_next    = now_count;
    head_slot_next    = head_slot;
    tail_slot_next    = tail_slot;
    list_empty_next   = list_empty;
    member_flag_next  = member_flag;
    pend_valid_next   = pend_valid;
    pend_slot_next    = pend_slot;
    result_valid_next = 1'b0;
    closed_slot_next  = closed_slot;
    last_of_run_next  = last_of_run;
    prev_we           = 1'b0;
    prev_wa           = '0;
    prev_wd           = '0;
    next_we           = 1'b0;
    next_wa           = '0;
    next_wd           = '0;
    deadline_we       = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          op_reg_next   = operation;
          slot_reg_next = slot_ext;
          unique case (operation)
            itel_pkg::OP_TOUCH: begin
              if (slot_ok) begin
                state_next = member_hit ? ST_UNLINK : ST_APPEND;
              end
            end
            itel_pkg::OP_REMOVE: begin
              if (member_hit) begin
                state_next = ST_UNLINK;
              end
            end
            itel_pkg::OP_TICK: begin
              now_count_next = now_count + TIME_BITS'(1);
              state_next     = ST_HEAD;
            end
            default: begin
            end
          endcase
        end
      end

      ST_UNLINK: begin
        // The read data holds this slot's neighbors.
        priority if (head_slot == slot_reg && tail_slot == slot_reg) begin
          list_empty_next = 1'b1;
          head_slot_next  = '0;
          tail_slot_next  = '0;
        end else if (head_slot == slot_reg) begin
          head_slot_next = rd_next;
        end else if (tail_slot == slot_reg) begin
          tail_slot_next = rd_prev;
        end else begin
          next_we = 1'b1;
          next_wa = rd_prev;
          next_wd = rd_next;
          prev_we = 1'b1;
          prev_wa = rd_next;
          prev_wd = rd_prev;
        end
        member_flag_next[slot_reg] = 1'b0;
        if (op_reg == itel_pkg::OP_REMOVE) begin
          result_valid_next = 1'b1;
          closed_slot_next  = SF_W'(slot_reg);
          last_of_run_next  = 1'b1;
          state_next        = ST_IDLE;
        end else begin
          state_next = ST_APPEND;
        end
      end

      ST_APPEND: begin
        deadline_we = 1'b1;
        if (list_empty) begin
          head_slot_next  = slot_reg;
          list_empty_next = 1'b0;
        end else begin
          next_we = 1'b1;
          next_wa = tail_slot;
          next_wd = slot_reg;
          prev_we = 1'b1;
          prev_wa = slot_reg;
          prev_wd = tail_slot;
        end
        tail_slot_next             = slot_reg;
        member_flag_next[slot_reg] = 1'b1;
        state_next                 = ST_IDLE;
      end

      ST_HEAD: begin
        // The head's deadline and successor are read in this cycle.
        if (list_empty) begin
          if (pend_valid) begin
            result_valid_next = 1'b1;
            closed_slot_next  = SF_W'(pend_slot);
            last_of_run_next  = 1'b1;
          end
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end else begin
          state_next = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (expired) begin
          if (head_slot == tail_slot) begin
            list_empty_next = 1'b1;
            head_slot_next  = '0;
            tail_slot_next  = '0;
          end else begin
            head_slot_next = rd_next;
          end
          member_flag_next[head_slot] = 1'b0;
          if (pend_valid) begin
            result_valid_next = 1'b1;
            closed_slot_next  = SF_W'(pend_slot);
            last_of_run_next  = 1'b0;
          end
          pend_valid_next = 1'b1;
          pend_slot_next  = head_slot;
          state_next      = ST_HEAD;
        end else begin
          if (pend_valid) begin
            result_valid_next = 1'b1;
            closed_slot_next  = SF_W'(pend_slot);
            last_of_run_next  = 1'b1;
          end
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      now_count    <= '0;
      head_slot    <= '0;
      tail_slot    <= '0;
      list_empty   <= 1'b1;
      member_flag  <= '0;
      pend_valid   <= 1'b0;
      result_valid <= 1'b0;
      timeout_reg  <= itel_pkg::TIMEOUT_RESET;
    end else begin
      state        <= state_next;
      now_count    <= now_count_next;
      head_slot    <= head_slot_next;
      tail_slot    <= tail_slot_next;
      list_empty   <= list_empty_next;
      member_flag  <= member_flag_next;
      pend_valid   <= pend_valid_next;
      result_valid <= result_valid_next;
      if (timeout_valid && timeout_ready) begin
        timeout_reg <= timeout_ticks;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    op_reg      <= op_reg_next;
    slot_reg    <= slot_reg_next;
    pend_slot   <= pend_slot_next;
    closed_slot <= closed_slot_next;
    last_of_run <= last_of_run_next;
  end

  // Memories with registered read data.
  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (deadline_we) begin
      deadline_mem[slot_reg] <= deadline_wd;
    end
    rd_prev     <= prev_mem[rd_addr];
    rd_next     <= next_mem[rd_addr];
    rd_deadline <= deadline_mem[rd_addr];
  end

endmodule

FILE: sv/itel_checker.sv
// ----------------------------------------------------------------------------
// Idle timeout expiry list checker
// Port-level assertions on command, result and reset behavior.
// ----------------------------------------------------------------------------
module itel_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic [itel_pkg::OP_W-1:0]         operation,
  input logic                              result_valid,
  input logic                              last_of_run
);

  // A touch never produces a result word.
  a_touch_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == itel_pkg::OP_TOUCH) |=> !result_valid)
    else $error("result word after a touch");

  // The unused code completes at once and reports nothing.
  a_nop_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && operation == itel_pkg::OP_NOP) |=> (!busy && !result_valid))
    else $error("unused operation code left the block busy or reporting");

  // While a run is still open, the block must stay busy.
  a_open_run_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last_of_run) |-> busy)
    else $error("run left open while idle");

  // The word that closes a run is not followed directly by another.
  a_run_closed: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_of_run) |=> !result_valid)
    else $error("result word right after the end of a run");

  // Reset leaves the block idle and silent.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!busy && !result_valid))
    else $error("block not idle after reset");

endmodule

bind idle_timeout_expiry_list_core itel_checker u_itel_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .operation    (operation),
  .result_valid (result_valid),
  .last_of_run  (last_of_run)
);

FILE: dv/idle_timeout_expiry_list_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Idle timeout expiry list testbench
// Drives touch, remove, tick and unused command words into the expiry list.
// It predicts every closed slot with an ordered slot queue and compares each
// result word as it leaves the block.
// ----------------------------------------------------------------------------
module idle_timeout_expiry_list_core_tb;

  localparam int SLOT_COUNT   = itel_pkg::SLOTS_DEFAULT;
  localparam int TIME_W       = itel_pkg::TIME_BITS_DEFAULT;
  localparam int SLOT_W       = itel_pkg::SLOT_FIELD_W;
  localparam int OP_BITS      = itel_pkg::OP_W;
  localparam int TMO_W        = itel_pkg::TIMEOUT_W;
  // The longest legal wait is a tick that closes all 32 slots, and this limit is
  // many times the slowest correct run.
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 16;
  localparam logic [TMO_W-1:0] TIMEOUT_MAX = '1;

  // One expected result word: the slot to close and the end-of-run mark.
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              last_of_run;
  } closure_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [OP_BITS-1:0]   operation = itel_pkg::OP_TOUCH;
  logic [SLOT_W-1:0]    slot_index = '0;
  logic                 result_valid;
  logic [SLOT_W-1:0]    closed_slot;
  logic                 last_of_run;
  logic                 timeout_valid = 1'b0;
  logic                 timeout_ready;
  logic [TMO_W-1:0]     timeout_ticks = '0;

  // Predicted state of the block. The linked list inside the block is just an
  // order of slots from oldest touch to newest touch, so a queue holds it.
  logic [TIME_W-1:0]    now_tick = '0;
  logic [TMO_W-1:0]     idle_ticks = itel_pkg::TIMEOUT_RESET;
  logic [TIME_W-1:0]    due_tick [SLOT_COUNT];
  logic [SLOT_W-1:0]    lru_order [$];
  closure_t             pending_closures [$];

  int fail_count = 0;
  int quiet_cycles = 0;
  int idle_pct = 30;
  bit start_held = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  idle_timeout_expiry_list_core u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .slot_index    (slot_index),
    .result_valid  (result_valid),
    .closed_slot   (closed_slot),
    .last_of_run   (last_of_run),
    .timeout_valid (timeout_valid),
    .timeout_ready (timeout_ready),
    .timeout_ticks (timeout_ticks)
  );

  // Position of a slot in the touch order, or -1 when it is not a member.
  function automatic int order_pos(input logic [SLOT_W-1:0] slot);
    int i;
    for (i = 0; i < lru_order.size(); i++) begin
      if (lru_order[i] == slot) return i;
    end
    return -1;
  endfunction

  // A deadline has passed when now is ahead of it by less than half the time
  // range. A deadline equal to now has not passed yet.
  function automatic bit is_overdue(input logic [TIME_W-1:0] due);
    logic [TIME_W-1:0] lag;
    lag = now_tick - due;
    return (lag != '0) && !lag[TIME_W-1];
  endfunction

  // Updates the predicted state for one accepted command word and queues the
  // result words that it must cause.
  task automatic predict_closures(input logic [OP_BITS-1:0] op,
                                  input logic [SLOT_W-1:0] slot);
    int       pos;
    int       runs;
    closure_t word;
    pos  = order_pos(slot);
    runs = 0;
    case (op)
      itel_pkg::OP_TOUCH: begin
        if (pos >= 0) lru_order.delete(pos);
        due_tick[slot] = now_tick + TIME_W'(idle_ticks);
        lru_order.push_back(slot);
      end
      itel_pkg::OP_REMOVE: begin
        // Removing a slot that is not in the list is silently dropped.
        if (pos >= 0) begin
          lru_order.delete(pos);
          word.slot        = slot;
          word.last_of_run = 1'b1;
          pending_closures.push_back(word);
        end
      end
      itel_pkg::OP_TICK: begin
        // Only the head is examined, so an unexpired head shields every slot
        // behind it even if those slots carry earlier deadlines.
        now_tick = now_tick + TIME_W'(1);
        while (lru_order.size() != 0 && is_overdue(due_tick[lru_order[0]])) begin
          word.slot        = lru_order.pop_front();
          word.last_of_run = 1'b0;
          pending_closures.push_back(word);
          runs++;
        end
        if (runs > 0) pending_closures[pending_closures.size() - 1].last_of_run = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic drop_start();
    if (start_held) begin
      start      <= 1'b0;
      start_held = 1'b0;
    end
  endtask

  // Presents one command word, waits until the block takes it, then either
  // keeps start high for the next word or drops start and pauses.
  task automatic issue_command(input logic [OP_BITS-1:0] op,
                               input logic [SLOT_W-1:0] slot);
    start      <= 1'b1;
    operation  <= op;
    slot_index <= slot;
    start_held = 1'b1;
    do @(posedge clk); while (busy);
    predict_closures(op, slot);
    if ($urandom_range(0, 99) < idle_pct) begin
      drop_start();
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // The timeout register is only written while the block is idle: every
  // expected word has arrived and the sequencer has let go of busy. The extra
  // cycles cover a tick that closes nothing but is still walking the list.
  task automatic set_idle_timeout(input logic [TMO_W-1:0] value);
    drop_start();
    do @(posedge clk); while (pending_closures.size() != 0 || busy);
    repeat (4) @(posedge clk);
    timeout_valid <= 1'b1;
    timeout_ticks <= value;
    do @(posedge clk); while (!timeout_ready);
    timeout_valid <= 1'b0;
    idle_ticks = value;
  endtask

  // Short directed sequence. The first touch uses the reset timeout, so that
  // slot sits at the head with a far deadline and blocks the slots behind it
  // until it is removed. It also covers a move to the tail, removal of an
  // absent slot, the unused code, a deadline equal to now, a multi-slot run,
  // and a deadline far ahead of now at the largest timeout.
  task automatic test_directed_commands();
    issue_command(itel_pkg::OP_TOUCH, 5'd12);
    set_idle_timeout(20'd1);
    issue_command(itel_pkg::OP_TOUCH, 5'd0);
    issue_command(itel_pkg::OP_TOUCH, 5'd31);
    issue_command(itel_pkg::OP_TOUCH, 5'd0);
    issue_command(itel_pkg::OP_REMOVE, 5'd5);
    issue_command(itel_pkg::OP_NOP, 5'd31);
    issue_command(itel_pkg::OP_NOP, 5'd0);
    issue_command(itel_pkg::OP_REMOVE, 5'd31);
    issue_command(itel_pkg::OP_TICK, 5'd0);
    issue_command(itel_pkg::OP_TICK, 5'd31);
    issue_command(itel_pkg::OP_REMOVE, 5'd12);
    issue_command(itel_pkg::OP_TICK, 5'd0);
    issue_command(itel_pkg::OP_TICK, 5'd0);
    issue_command(itel_pkg::OP_TOUCH, 5'd21);
    issue_command(itel_pkg::OP_TOUCH, 5'd10);
    issue_command(itel_pkg::OP_TOUCH, 5'd21);
    issue_command(itel_pkg::OP_TICK, 5'd0);
    issue_command(itel_pkg::OP_TICK, 5'd0);
    set_idle_timeout(TIMEOUT_MAX);
    issue_command(itel_pkg::OP_TOUCH, 5'd7);
    issue_command(itel_pkg::OP_TICK, 5'd7);
    issue_command(itel_pkg::OP_REMOVE, 5'd7);
  endtask

  // Fills every slot in a shuffled order and lets all of them expire on one
  // tick, which gives the longest run of result words. No idling here.
  task automatic test_full_list_run();
    logic [SLOT_W-1:0] deck [SLOT_COUNT];
    logic [SLOT_W-1:0] held;
    int i;
    int j;
    for (i = 0; i < SLOT_COUNT; i++) deck[i] = SLOT_W'(i);
    for (i = SLOT_COUNT - 1; i > 0; i--) begin
      j       = $urandom_range(0, i);
      held    = deck[i];
      deck[i] = deck[j];
      deck[j] = held;
    end
    set_idle_timeout(20'd1);
    idle_pct = 0;
    for (i = 0; i < SLOT_COUNT; i++) issue_command(itel_pkg::OP_TOUCH, deck[i]);
    repeat (3) issue_command(itel_pkg::OP_TICK, SLOT_W'($urandom_range(0, SLOT_COUNT - 1)));
    idle_pct = 30;
  endtask

  // Random traffic over several timeout settings. Removes mostly pick a slot
  // that is in the list so that they close something. Unused codes and
  // removes of absent slots are noise and do not count toward a phase.
  task automatic test_random_traffic();
    logic [TMO_W-1:0]   phase_timeout [6];
    logic [SLOT_W-1:0]  slot;
    logic [OP_BITS-1:0] op;
    int p;
    int pick;
    int counted;
    phase_timeout[0] = 20'd2;
    phase_timeout[1] = TMO_W'($urandom_range(1, 8));
    phase_timeout[2] = TIMEOUT_MAX;
    phase_timeout[3] = TMO_W'($urandom_range(9, 1048575));
    phase_timeout[4] = 20'd1;
    phase_timeout[5] = TMO_W'($urandom_range(3, 40));
    for (p = 0; p < 6; p++) begin
      set_idle_timeout(phase_timeout[p]);
      // One whole phase runs back to back with no pauses at all.
      idle_pct = (p == 2) ? 0 : 30;
      counted  = 0;
      while (counted < 24) begin
        pick = $urandom_range(0, 99);
        slot = SLOT_W'($urandom_range(0, SLOT_COUNT - 1));
        if (pick < 45) begin
          op = itel_pkg::OP_TOUCH;
        end else if (pick < 62) begin
          op = itel_pkg::OP_REMOVE;
          if (lru_order.size() != 0 && $urandom_range(0, 3) != 0)
            slot = lru_order[$urandom_range(0, lru_order.size() - 1)];
        end else if (pick < 92) begin
          op = itel_pkg::OP_TICK;
        end else begin
          op = itel_pkg::OP_NOP;
        end
        if (op != itel_pkg::OP_NOP &&
            !(op == itel_pkg::OP_REMOVE && order_pos(slot) < 0)) counted++;
        issue_command(op, slot);
      end
    end
    idle_pct = 30;
  endtask

  // Result words cannot be held off, so every strobe is checked on the edge
  // that ends its cycle against the oldest expectation.
  always @(posedge clk) begin
    closure_t want;
    if (!rst && result_valid) begin
      if (pending_closures.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected word, expected none, actual slot %0d last %0b",
                 $time, closed_slot, last_of_run);
      end else begin
        want = pending_closures.pop_front();
        if (closed_slot !== want.slot) begin
          fail_count++;
          $display("%0t: closed_slot mismatch, expected %0d, actual %0d",
                   $time, want.slot, closed_slot);
        end
        if (last_of_run !== want.last_of_run) begin
          fail_count++;
          $display("%0t: last_of_run mismatch, expected %0b, actual %0b",
                   $time, want.last_of_run, last_of_run);
        end
      end
    end
  end

  // Watchdog: any accepted command, result or register write restarts it.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (timeout_valid && timeout_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed_commands();
    test_full_list_run();
    test_random_traffic();
    drop_start();
    do @(posedge clk); while (pending_closures.size() != 0 || busy);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_closures.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/itel_pkg.sv
sv/idle_timeout_expiry_list_core.sv
sv/itel_checker.sv
dv/idle_timeout_expiry_list_core_tb.sv
